[rtl/core/lpht_pkg.sv]
package lpht_pkg;

    // Field widths of one table entry and of the stream payloads.
    localparam int KEY_W  = 32;
    localparam int POS_W  = 16;
    localparam int TICK_W = 32;

    // One RAM word holds {last_used, position, key}, key in the low bits.
    localparam int ENTRY_W = KEY_W + POS_W + TICK_W;

    localparam int ENTRIES_DEFAULT = 8;

    // Start value of the oldest-tick search.
    localparam logic [TICK_W-1:0] TICK_MAX = 32'hFFFF_FFFF;

    // Operation codes carried in the slave-side tuser.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_STORE  = 1'b1;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic start;   // clear the match and victim trackers
        logic step;    // one entry is presented this cycle
    } scan_ctrl_t;

endpackage

[rtl/core/lpht_ram.sv]
module lpht_ram #(
    parameter int WIDTH = lpht_pkg::ENTRY_W,
    parameter int DEPTH = lpht_pkg::ENTRIES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lpht_scan.sv]
// Shared compare unit: one entry per step, tracking the first key match
// and the entry with the strictly smallest last-used tick.
module lpht_scan #(
    parameter int ENTRIES = lpht_pkg::ENTRIES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpht_pkg::scan_ctrl_t          ctrl,
    input  logic [$clog2(ENTRIES)-1:0]    idx,
    input  logic [lpht_pkg::KEY_W-1:0]    search_key,
    input  logic [lpht_pkg::KEY_W-1:0]    entry_key,
    input  logic [lpht_pkg::POS_W-1:0]    entry_pos,
    input  logic [lpht_pkg::TICK_W-1:0]   entry_tick,
    output logic                          hit,
    output logic [$clog2(ENTRIES)-1:0]    match_idx,
    output logic [lpht_pkg::POS_W-1:0]    match_pos,
    output logic [$clog2(ENTRIES)-1:0]    victim_idx
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic                        hit_reg,    hit_next;
    logic [IDX_W-1:0]            midx_reg,   midx_next;
    logic [lpht_pkg::POS_W-1:0]  mpos_reg,   mpos_next;
    logic [lpht_pkg::TICK_W-1:0] oldest_reg, oldest_next;
    logic [IDX_W-1:0]            vidx_reg,   vidx_next;
    logic                        key_eq;
    logic                        tick_lt;

    assign key_eq  = (entry_key == search_key);
    assign tick_lt = (entry_tick < oldest_reg);

    always_comb
    begin
        hit_next    = hit_reg;
        midx_next   = midx_reg;
        mpos_next   = mpos_reg;
        oldest_next = oldest_reg;
        vidx_next   = vidx_reg;
        if (ctrl.start)
        begin
            hit_next    = 1'b0;
            oldest_next = lpht_pkg::TICK_MAX;
            vidx_next   = '0;
        end
        else if (ctrl.step)
        begin
            if (!hit_reg && key_eq)
            begin
                hit_next  = 1'b1;
                midx_next = idx;
                mpos_next = entry_pos;
            end
            if (tick_lt)
            begin
                oldest_next = entry_tick;
                vidx_next   = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg    <= 1'b0;
            oldest_reg <= lpht_pkg::TICK_MAX;
            vidx_reg   <= '0;
        end
        else
        begin
            hit_reg    <= hit_next;
            oldest_reg <= oldest_next;
            vidx_reg   <= vidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        midx_reg <= midx_next;
        mpos_reg <= mpos_next;
    end

    assign hit        = hit_reg;
    assign match_idx  = midx_reg;
    assign match_pos  = mpos_reg;
    assign victim_idx = vidx_reg;

endmodule

[rtl/core/lru_position_history_table.sv]
// Channel   Direction  Transfer payload
// s_axis    in         tuser: opcode; tdata: key, position, now_tick
// m_axis    out        tuser: hit;    tdata: found_position
//
// Per request, S_SCAN reads one entry per cycle through the single RAM read
// port, S_DRAIN waits out the read latency, and S_FINISH writes the table and
// loads the result, offered as s_axis_tready rises. s_axis_tready is high only
// in S_IDLE, so no request is taken before the last is done. Reset clears the
// valid bits at once, so an entry never stored reads as zero. A stalled m_axis
// holds the sequencer in its last state until the result register is free.
module lru_position_history_table #(
    parameter int ENTRIES = lpht_pkg::ENTRIES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // [31:0] key, [47:32] position, [79:48] now_tick
    input  logic [0:0]  s_axis_tuser,   // [0] opcode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] found_position
    output logic [0:0]  m_axis_tuser    // [0] hit
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam int KW = lpht_pkg::KEY_W;
    localparam int PW = lpht_pkg::POS_W;
    localparam int TW = lpht_pkg::TICK_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]          state_reg,   state_next;
    logic [IDX_W-1:0]    addr_reg,    addr_next;
    logic                rd_pend_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_valid_reg;
    logic [ENTRIES-1:0]  valid_reg,   valid_next;
    logic                op_reg;
    logic [KW-1:0]       key_reg;
    logic [PW-1:0]       pos_reg;
    logic [TW-1:0]       tick_reg;
    logic                mvalid_reg,  mvalid_next;
    logic [PW-1:0]       mpos_reg;
    logic                mhit_reg;

    logic                s_fire;
    logic                out_free;
    logic                rd_en;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [lpht_pkg::ENTRY_W-1:0] ram_wdata;
    logic [lpht_pkg::ENTRY_W-1:0] ram_rdata;
    logic [lpht_pkg::ENTRY_W-1:0] entry_word;

    lpht_pkg::scan_ctrl_t scan_ctrl;
    logic                 scan_hit;
    logic [IDX_W-1:0]     scan_midx;
    logic [PW-1:0]        scan_mpos;
    logic [IDX_W-1:0]     scan_vidx;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !mvalid_reg || m_axis_tready;
    assign rd_en         = (state_reg == S_SCAN);

    // The write happens once, in the cycle the result register is loaded.
    assign ram_we    = (state_reg == S_FINISH) && out_free && (op_reg == lpht_pkg::OP_STORE);
    assign ram_waddr = scan_hit ? scan_midx : scan_vidx;
    assign ram_wdata = {tick_reg, pos_reg, key_reg};

    lpht_ram #(
        .WIDTH (lpht_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // An entry never stored reads as all zero, like the cleared table.
    assign entry_word = rd_valid_reg ? ram_rdata : '0;

    assign scan_ctrl.start = s_fire;
    assign scan_ctrl.step  = rd_pend_reg;

    lpht_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .idx        (rd_idx_reg),
        .search_key (key_reg),
        .entry_key  (entry_word[KW-1:0]),
        .entry_pos  (entry_word[KW+PW-1:KW]),
        .entry_tick (entry_word[KW+PW+TW-1:KW+PW]),
        .hit        (scan_hit),
        .match_idx  (scan_midx),
        .match_pos  (scan_mpos),
        .victim_idx (scan_vidx)
    );

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        valid_next  = valid_reg;
        mvalid_next = mvalid_reg;
        if (mvalid_reg && m_axis_tready)
        begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_SCAN;
                    addr_next  = '0;
                end
            end
            S_SCAN:
            begin
                if (addr_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next  = S_IDLE;
                    mvalid_next = 1'b1;
                    if (ram_we)
                    begin
                        valid_next[ram_waddr] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            addr_reg    <= '0;
            rd_pend_reg <= 1'b0;
            valid_reg   <= '0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_pend_reg <= rd_en;
            valid_reg   <= valid_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    // Payload registers: the latched request, the read tag and the result.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg   <= s_axis_tuser[0];
            key_reg  <= s_axis_tdata[KW-1:0];
            pos_reg  <= s_axis_tdata[KW+PW-1:KW];
            tick_reg <= s_axis_tdata[KW+PW+TW-1:KW+PW];
        end
        rd_idx_reg   <= addr_reg;
        rd_valid_reg <= valid_reg[addr_reg];
        if ((state_reg == S_FINISH) && out_free)
        begin
            mhit_reg <= scan_hit;
            mpos_reg <= (op_reg == lpht_pkg::OP_LOOKUP && scan_hit) ? scan_mpos : '0;
        end
    end

    assign m_axis_tvalid   = mvalid_reg;
    assign m_axis_tdata    = mpos_reg;
    assign m_axis_tuser[0] = mhit_reg;

    // An accepted request always starts a scan in the next cycle.
    a_fire_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (state_reg == S_SCAN) && (addr_reg == '0))
        else $error("accepted request did not start a scan");

    // RAM read data is only consumed while a scan is running.
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_SCAN) || (state_reg == S_DRAIN))
        else $error("read data returned outside a scan");

    // A table write always leaves its entry marked valid.
    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(ram_waddr)])
        else $error("written entry not marked valid");

    // Writing the table and loading the result happen together.
    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> mvalid_reg && (state_reg == S_IDLE))
        else $error("table write without result");

    // The number of valid entries never drops.
    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) >= $countones($past(valid_reg)))
        else $error("valid entry lost");

endmodule
